// ===== rtl/tkc_pkg.sv =====
package tkc_pkg;

  // Tile store capacity and the widths that follow from it.
  localparam int MAX_TILES = 2048;
  localparam int TILE_W    = 11;
  localparam int COUNT_W   = 12;

  // Reseeding of an empty cluster.
  localparam int            RESEED_TRIES = 16;
  localparam logic [31:0]   DEFAULT_SEED = 32'h00C0FFEE;
  localparam logic [31:0]   LFSR_MASK    = 32'h80200003;

  // Datapath widths.
  localparam int DIST_W = 36;   // sum of three squared differences
  localparam int SUM_W  = 36;   // weighted component sum
  localparam int WGT_W  = 18;   // cluster pixel weight
  localparam int DVD_W  = 34;   // divider dividend

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [10:0]        tile_index;
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    logic [6:0]         pixels;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  cluster;
    logic [11:0] tile_total;
    logic [4:0]  passes;
  } rsp_word_t;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    logic [6:0]         weight;
  } tile_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } cent_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [WGT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [WGT_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_SEED_TAKE_RD,
    ST_SEED_TAKE,
    ST_SEED_RD,
    ST_SEED_MUL,
    ST_SEED_CMP,
    ST_PASS_START,
    ST_ASG_RD,
    ST_ASG_MUL,
    ST_ASG_CMP,
    ST_ASG_WR,
    ST_ACC_ADD,
    ST_PASS_END,
    ST_UPD,
    ST_DIV,
    ST_RS_STEP,
    ST_RS_DIV,
    ST_RS_RD,
    ST_RS_CHK,
    ST_RUN_END
  } state_t;

endpackage

// ===== rtl/tkc_div.sv =====
module tkc_div (
  input  logic              clk,
  input  logic              rst,
  input  tkc_pkg::div_req_t req,
  output tkc_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(tkc_pkg::DVD_W + 1);

  logic [tkc_pkg::DVD_W-1:0] quo;
  logic [tkc_pkg::WGT_W-1:0] rem;
  logic [tkc_pkg::WGT_W-1:0] dsr;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [tkc_pkg::WGT_W:0]   trial;
  logic                      fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, quo[tkc_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(tkc_pkg::DVD_W);
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[tkc_pkg::DVD_W-2:0], fits};
        rem <= fits ? tkc_pkg::WGT_W'(trial - {1'b0, dsr}) : tkc_pkg::WGT_W'(trial);
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/tile_kmeans_clustering.sv =====
// Tile k-means clustering engine.
// Commands arrive as words on the req channel (req_valid, req_stall) and each
// command produces exactly one word on the rsp channel (rsp_valid, rsp_stall).
// A word moves at a rising edge where valid is high and stall is low.
// Load, clear and a run with an empty store finish in the cycle they are
// accepted; their result word goes to the output or holding register. A read
// passes ST_READ while the assignment memory returns its data. A run walks the
// tile store through one read port: taking a seed reads a tile and stores it,
// choosing centroid k compares each tile with each earlier centroid, a pass
// assigns each tile to its nearest centroid and sums it, and the update divides
// each cluster's sums in the shared serial divider, which reseeding also uses.
// Only one command is in work at a time. The result sits in an output register;
// a second finished word can wait in a holding register, so a stalled receiver
// blocks new commands only once both are full. The seed register is written
// through cfg_we and cfg_wdata; the user must do so only while the engine is
// idle, as the block does not enforce it. Reset empties the store and both
// result registers; no clearing pass runs as only loaded entries are ever read.
module tile_kmeans_clustering #(
  parameter int CLUSTERS    = 4,
  parameter int TILE_PIXELS = 64,
  parameter int MAX_PASSES  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tkc_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tkc_pkg::rsp_word_t rsp,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int KW = $clog2(CLUSTERS);
  localparam int PW = $clog2(MAX_PASSES + 1);
  localparam int TW = tkc_pkg::TILE_W;
  localparam int CW = tkc_pkg::COUNT_W;

  tkc_pkg::state_t state, state_next;

  // Memories: tile data and per-tile cluster assignment.
  tkc_pkg::tile_t tile_mem [tkc_pkg::MAX_TILES];
  logic [KW-1:0]  asg_mem  [tkc_pkg::MAX_TILES];
  tkc_pkg::tile_t tile_q;
  logic [KW-1:0]  asg_q;

  logic [CW-1:0]  count;
  logic [31:0]    seed;
  logic [31:0]    lfsr;
  logic [PW-1:0]  last_passes;
  logic [PW-1:0]  pass;

  tkc_pkg::cent_t               cent [CLUSTERS];
  logic signed [tkc_pkg::SUM_W-1:0] sums [CLUSTERS][3];
  logic [tkc_pkg::WGT_W-1:0]    wsum [CLUSTERS];

  logic [TW-1:0]  idx;
  logic [TW-1:0]  best_i;
  logic [KW-1:0]  k;
  logic [KW-1:0]  kk;
  logic [KW-1:0]  bk;
  logic [KW-1:0]  acc_k;
  logic [1:0]     comp;
  logic [3:0]     tries;
  logic           found;
  logic           changed;
  logic           rd_bad;
  logic [tkc_pkg::DIST_W-1:0] md;
  logic [tkc_pkg::DIST_W-1:0] best;
  logic [tkc_pkg::DIST_W-1:0] bd;
  logic [33:0]    sq_l, sq_a, sq_b;
  logic signed [23:0] pr_l, pr_a, pr_b;

  // Result registers.
  tkc_pkg::rsp_word_t out_word, pend_word, res;
  logic           out_valid, pend_valid, done;

  tkc_pkg::div_req_t div_req;
  tkc_pkg::div_rsp_t div_rsp;

  tkc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Handshake.
  logic accept;
  logic out_take;
  assign req_stall = (state != tkc_pkg::ST_IDLE) || pend_valid;
  assign accept    = req_valid && !req_stall;
  assign out_take  = out_valid && !rsp_stall;
  assign rsp_valid = out_valid;
  assign rsp       = out_word;

  logic full;
  logic last_tile;
  assign full      = count == CW'(tkc_pkg::MAX_TILES);
  assign last_tile = {1'b0, idx} == count - CW'(1);

  // Distance of the current tile to centroid kk.
  tkc_pkg::cent_t     csel;
  logic signed [16:0] dl, da, db;
  logic [tkc_pkg::DIST_W-1:0] dist_sum;
  logic [tkc_pkg::DIST_W-1:0] md_new;
  logic               seed_better;
  assign csel = cent[kk];
  assign dl = $signed({2'b00, tile_q.lightness}) - $signed({csel.l[15], csel.l});
  assign da = $signed({tile_q.green_red[15], tile_q.green_red})
            - $signed({csel.a[15], csel.a});
  assign db = $signed({tile_q.blue_yellow[15], tile_q.blue_yellow})
            - $signed({csel.b[15], csel.b});
  assign dist_sum = tkc_pkg::DIST_W'(sq_l) + tkc_pkg::DIST_W'(sq_a)
                  + tkc_pkg::DIST_W'(sq_b);
  assign md_new = (kk == '0 || dist_sum < md) ? dist_sum : md;
  assign seed_better = (tile_q.weight != '0) && (!found || md_new > best);

  logic [KW-1:0] bk_final;
  assign bk_final = (tile_q.weight == '0) ? '0 : bk;

  // Rounded division input: magnitude plus half the weight.
  logic signed [tkc_pkg::SUM_W-1:0] s_sel;
  logic [tkc_pkg::SUM_W-1:0]        s_mag;
  logic [tkc_pkg::WGT_W-1:0]        w_sel;
  logic signed [15:0]               q_signed;
  assign s_sel = sums[k][comp];
  assign s_mag = s_sel[tkc_pkg::SUM_W-1] ? tkc_pkg::SUM_W'(-s_sel) : s_sel;
  assign w_sel = wsum[k];
  assign q_signed = s_sel[tkc_pkg::SUM_W-1] ? -$signed(div_rsp.quotient[15:0])
                                            : $signed(div_rsp.quotient[15:0]);

  logic [31:0] lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ tkc_pkg::LFSR_MASK) : (lfsr >> 1);

  logic last_k;
  assign last_k = k == KW'(CLUSTERS - 1);

  // Next state, result and divider requests.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    res        = '0;
    div_req    = '0;
    res.tile_total = count;
    res.passes     = 5'(last_passes);
    unique case (state)
      tkc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.command)
            tkc_pkg::CMD_LOAD: begin
              done = 1'b1;
              if (full) begin
                res.status = tkc_pkg::STAT_FULL;
              end else begin
                res.tile_total = count + CW'(1);
              end
            end
            tkc_pkg::CMD_RUN: begin
              if (count == '0) begin
                done       = 1'b1;
                res.status = tkc_pkg::STAT_RANGE;
                res.passes = '0;
              end else begin
                state_next = tkc_pkg::ST_SEED_TAKE_RD;
              end
            end
            tkc_pkg::CMD_READ: state_next = tkc_pkg::ST_READ;
            tkc_pkg::CMD_CLEAR: begin
              done           = 1'b1;
              res.tile_total = '0;
            end
            default: state_next = tkc_pkg::ST_IDLE;
          endcase
        end
      end
      tkc_pkg::ST_READ: begin
        done        = 1'b1;
        res.status  = rd_bad ? tkc_pkg::STAT_RANGE : tkc_pkg::STAT_OK;
        res.cluster = rd_bad ? 2'd0 : 2'(asg_q);
        state_next  = tkc_pkg::ST_IDLE;
      end
      tkc_pkg::ST_SEED_TAKE_RD: state_next = tkc_pkg::ST_SEED_TAKE;
      tkc_pkg::ST_SEED_TAKE: begin
        state_next = last_k ? tkc_pkg::ST_PASS_START : tkc_pkg::ST_SEED_RD;
      end
      tkc_pkg::ST_SEED_RD:  state_next = tkc_pkg::ST_SEED_MUL;
      tkc_pkg::ST_SEED_MUL: state_next = tkc_pkg::ST_SEED_CMP;
      tkc_pkg::ST_SEED_CMP: begin
        if (kk != k - KW'(1)) begin
          state_next = tkc_pkg::ST_SEED_MUL;
        end else if (last_tile) begin
          state_next = tkc_pkg::ST_SEED_TAKE_RD;
        end else begin
          state_next = tkc_pkg::ST_SEED_RD;
        end
      end
      tkc_pkg::ST_PASS_START: state_next = tkc_pkg::ST_ASG_RD;
      tkc_pkg::ST_ASG_RD:     state_next = tkc_pkg::ST_ASG_MUL;
      tkc_pkg::ST_ASG_MUL:    state_next = tkc_pkg::ST_ASG_CMP;
      tkc_pkg::ST_ASG_CMP: begin
        state_next = (kk == KW'(CLUSTERS - 1)) ? tkc_pkg::ST_ASG_WR : tkc_pkg::ST_ASG_MUL;
      end
      tkc_pkg::ST_ASG_WR: state_next = tkc_pkg::ST_ACC_ADD;
      tkc_pkg::ST_ACC_ADD: begin
        state_next = last_tile ? tkc_pkg::ST_PASS_END : tkc_pkg::ST_ASG_RD;
      end
      tkc_pkg::ST_PASS_END: begin
        // The centroid update after the final allowed pass is never used.
        if ((!changed && pass != '0) || pass == PW'(MAX_PASSES - 1)) begin
          state_next = tkc_pkg::ST_RUN_END;
        end else begin
          state_next = tkc_pkg::ST_UPD;
        end
      end
      tkc_pkg::ST_UPD: begin
        if (w_sel != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = tkc_pkg::DVD_W'(s_mag) + tkc_pkg::DVD_W'(w_sel >> 1);
          div_req.divisor  = w_sel;
          state_next       = tkc_pkg::ST_DIV;
        end else begin
          state_next = tkc_pkg::ST_RS_STEP;
        end
      end
      tkc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (comp != 2'd2) begin
            state_next = tkc_pkg::ST_UPD;
          end else begin
            state_next = last_k ? tkc_pkg::ST_PASS_START : tkc_pkg::ST_UPD;
          end
        end
      end
      tkc_pkg::ST_RS_STEP: begin
        div_req.start    = 1'b1;
        div_req.dividend = tkc_pkg::DVD_W'(lfsr_step);
        div_req.divisor  = tkc_pkg::WGT_W'(count);
        state_next       = tkc_pkg::ST_RS_DIV;
      end
      tkc_pkg::ST_RS_DIV: begin
        if (div_rsp.done) begin
          state_next = tkc_pkg::ST_RS_RD;
        end
      end
      tkc_pkg::ST_RS_RD: state_next = tkc_pkg::ST_RS_CHK;
      tkc_pkg::ST_RS_CHK: begin
        if (tile_q.weight != '0 || tries == 4'(tkc_pkg::RESEED_TRIES - 1)) begin
          state_next = last_k ? tkc_pkg::ST_PASS_START : tkc_pkg::ST_UPD;
        end else begin
          state_next = tkc_pkg::ST_RS_STEP;
        end
      end
      tkc_pkg::ST_RUN_END: begin
        done       = 1'b1;
        state_next = tkc_pkg::ST_IDLE;
      end
      default: state_next = tkc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory ports. Reads are issued every cycle; the address holds while a
  // tile is in work, so the registered data stays put.
  logic          load_wr;
  logic          asg_wr;
  logic [TW-1:0] asg_addr;
  assign load_wr  = accept && req.command == tkc_pkg::CMD_LOAD && !full;
  assign asg_wr   = load_wr || state == tkc_pkg::ST_ASG_WR;
  assign asg_addr = (state == tkc_pkg::ST_IDLE) ?
                    (load_wr ? count[TW-1:0] : req.tile_index) : idx;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      tile_mem[count[TW-1:0]] <= '{
        lightness:   req.lightness,
        green_red:   req.green_red,
        blue_yellow: req.blue_yellow,
        weight:      (int'(req.pixels) > TILE_PIXELS) ? 7'(TILE_PIXELS)
                                                      : req.pixels
      };
    end
    tile_q <= tile_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (asg_wr) begin
      asg_mem[asg_addr] <= load_wr ? '0 : bk_final;
    end
    asg_q <= asg_mem[asg_addr];
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      seed        <= '0;
      lfsr        <= tkc_pkg::DEFAULT_SEED;
      last_passes <= '0;
      idx         <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      unique case (state)
        tkc_pkg::ST_IDLE: begin
          if (accept) begin
            rd_bad <= {1'b0, req.tile_index} >= count;
            case (req.command)
              tkc_pkg::CMD_LOAD: begin
                if (!full) begin
                  count <= count + CW'(1);
                end
              end
              tkc_pkg::CMD_RUN: begin
                if (count == '0) begin
                  last_passes <= '0;
                end else begin
                  lfsr <= (seed != '0) ? seed : tkc_pkg::DEFAULT_SEED;
                  idx  <= '0;
                  k    <= '0;
                  pass <= '0;
                end
              end
              tkc_pkg::CMD_CLEAR: count <= '0;
              default: count <= count;
            endcase
          end
        end
        tkc_pkg::ST_SEED_TAKE: begin
          cent[k] <= '{l: $signed({1'b0, tile_q.lightness}),
                       a: tile_q.green_red, b: tile_q.blue_yellow};
          k      <= k + KW'(1);
          idx    <= '0;
          found  <= 1'b0;
          // With no non-empty tile the next seed falls back to tile 0.
          best_i <= '0;
        end
        tkc_pkg::ST_SEED_RD: kk <= '0;
        tkc_pkg::ST_SEED_MUL, tkc_pkg::ST_ASG_MUL: begin
          sq_l <= 34'(dl * dl);
          sq_a <= 34'(da * da);
          sq_b <= 34'(db * db);
        end
        tkc_pkg::ST_SEED_CMP: begin
          md <= md_new;
          if (kk != k - KW'(1)) begin
            kk <= kk + KW'(1);
          end else begin
            if (seed_better) begin
              found  <= 1'b1;
              best   <= md_new;
              best_i <= idx;
            end
            if (last_tile) begin
              idx <= seed_better ? idx : best_i;
            end else begin
              idx <= idx + TW'(1);
            end
          end
        end
        tkc_pkg::ST_PASS_START: begin
          idx     <= '0;
          changed <= 1'b0;
          for (int c = 0; c < CLUSTERS; c++) begin
            wsum[c] <= '0;
            for (int j = 0; j < 3; j++) begin
              sums[c][j] <= '0;
            end
          end
        end
        tkc_pkg::ST_ASG_RD: kk <= '0;
        tkc_pkg::ST_ASG_CMP: begin
          if (kk == '0 || dist_sum < bd) begin
            bd <= dist_sum;
            bk <= kk;
          end
          kk <= kk + KW'(1);
        end
        tkc_pkg::ST_ASG_WR: begin
          // The first pass compares against the cleared assignment.
          if (bk_final != ((pass == '0) ? '0 : asg_q)) begin
            changed <= 1'b1;
          end
          acc_k <= bk_final;
          pr_l  <= $signed({1'b0, tile_q.lightness}) * $signed({1'b0, tile_q.weight});
          pr_a  <= 24'(tile_q.green_red * $signed({1'b0, tile_q.weight}));
          pr_b  <= 24'(tile_q.blue_yellow * $signed({1'b0, tile_q.weight}));
        end
        tkc_pkg::ST_ACC_ADD: begin
          sums[acc_k][0] <= sums[acc_k][0] + tkc_pkg::SUM_W'(pr_l);
          sums[acc_k][1] <= sums[acc_k][1] + tkc_pkg::SUM_W'(pr_a);
          sums[acc_k][2] <= sums[acc_k][2] + tkc_pkg::SUM_W'(pr_b);
          wsum[acc_k]    <= wsum[acc_k] + tkc_pkg::WGT_W'(tile_q.weight);
          idx            <= idx + TW'(1);
        end
        tkc_pkg::ST_PASS_END: begin
          last_passes <= pass + PW'(1);
          k           <= '0;
          comp        <= '0;
          tries       <= '0;
        end
        tkc_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            unique case (comp)
              2'd0: cent[k].l <= q_signed;
              2'd1: cent[k].a <= q_signed;
              default: cent[k].b <= q_signed;
            endcase
            if (comp != 2'd2) begin
              comp <= comp + 2'd1;
            end else begin
              comp <= '0;
              k    <= k + KW'(1);
              if (last_k) begin
                pass <= pass + PW'(1);
              end
            end
          end
        end
        tkc_pkg::ST_RS_STEP: lfsr <= lfsr_step;
        tkc_pkg::ST_RS_DIV: begin
          if (div_rsp.done) begin
            idx <= div_rsp.remainder[TW-1:0];
          end
        end
        tkc_pkg::ST_RS_CHK: begin
          if (tile_q.weight != '0 || tries == 4'(tkc_pkg::RESEED_TRIES - 1)) begin
            if (tile_q.weight != '0) begin
              cent[k] <= '{l: $signed({1'b0, tile_q.lightness}),
                           a: tile_q.green_red, b: tile_q.blue_yellow};
            end
            tries <= '0;
            k     <= k + KW'(1);
            if (last_k) begin
              pass <= pass + PW'(1);
            end
          end else begin
            tries <= tries + 4'd1;
          end
        end
        default: idx <= idx;
      endcase
    end
  end

  // Output register with one holding register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (done) begin
      if (!out_valid || out_take) begin
        out_word  <= res;
        out_valid <= 1'b1;
      end else begin
        pend_word  <= res;
        pend_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (pend_valid) begin
        out_word   <= pend_word;
        pend_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // A held word always has a word in front of it.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("holding register full while output register empty");

  // The store never grows past its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(tkc_pkg::MAX_TILES))
    else $error("tile count beyond capacity");

  // A finished run reports between one and the maximum number of passes.
  a_run_passes: assert property (@(posedge clk) disable iff (rst)
    state == tkc_pkg::ST_RUN_END |->
      (last_passes != '0 && last_passes <= PW'(MAX_PASSES)))
    else $error("run finished with an impossible pass count");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
